// ===== sv/blss_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the bounded LIFO stack with search.
// No dependencies; imported by blss_core and the top level.
package blss_pkg;

	// Command codes carried by the cmd field
	localparam logic [2:0] CMD_PUSH   = 3'd0;
	localparam logic [2:0] CMD_POP    = 3'd1;
	localparam logic [2:0] CMD_PEEK   = 3'd2;
	localparam logic [2:0] CMD_CLEAR  = 3'd3;
	localparam logic [2:0] CMD_SEARCH = 3'd4;

	// Capacity after reset
	localparam logic [8:0] CAP_RESET = 9'd256;

	// One result item as handed from the core to the output register
	typedef struct packed {
		logic        status;
		logic [31:0] data;
		logic        found;
		logic [7:0]  position;
		logic [8:0]  count;
		logic        empty;
		logic        full;
	} blss_res_t;

endpackage

// ===== sv/bounded_lifo_stack_with_search_unit.sv =====
`timescale 1ns / 1ps
// Bounded LIFO stack of signed words with a top-down search.
// Channels: command in (cmd_valid, cmd_stall, cmd, value), result out
// (res_valid, res_stall and one port per result field), and a capacity write
// channel (cfg_valid, cfg_ready, capacity) that is always ready.
// Each accepted command item gives exactly one result item.
// Push, pop, peek, clear and unknown codes go from the accepting edge to the
// done state, from which the result moves into the result register; a search
// first compares entries (up to the fill level) before it is done, as the
// single read port of the entry store is walked one entry per cycle from
// the top down.
// One command at a time: cmd_stall stays high until the result moves on.
// A finished result sits in the output register while the next command is
// already being worked on; while res_stall is high the result holds and the
// core waits with its own result, holding cmd_stall high.
// Reset: fill level 0, capacity 256, no result pending. The entry store is
// not cleared; entries are only read after a push wrote them.
// Depends on blss_pkg and blss_core.
module bounded_lifo_stack_with_search_unit import blss_pkg::*; #(
	parameter int DEPTH     = 256,
	parameter int WORD_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [2:0]         cmd,
	input  logic signed [31:0] value,
	output logic               res_valid,
	input  logic               res_stall,
	output logic               status,
	output logic signed [31:0] data,
	output logic               found,
	output logic [7:0]         position,
	output logic [8:0]         count,
	output logic               empty_res,
	output logic               full_res,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [8:0]         capacity
);

	logic [8:0]           cap_q;
	logic                 res_valid_q;
	blss_res_t            res_q;
	logic signed [63:0]   value_ext;
	logic [WORD_BITS-1:0] word;
	logic                 core_valid;
	logic                 take;
	blss_res_t            core_res;

	// Hold the capacity register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= capacity;
		end
	end

	// Fit the input value to the stored word width
	assign value_ext = 64'(value);
	assign word      = value_ext[WORD_BITS-1:0];

	blss_core #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.key       (word),
		.cmd_stall (cmd_stall),
		.cap       (cap_q),
		.res_valid (core_valid),
		.res_take  (take),
		.res       (core_res)
	);

	// Output register: load when empty or when the current item leaves
	assign take = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= core_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && core_valid) begin
			res_q <= core_res;
		end
	end

	assign res_valid = res_valid_q;
	assign status    = res_q.status;
	assign data      = signed'(res_q.data);
	assign found     = res_q.found;
	assign position  = res_q.position;
	assign count     = res_q.count;
	assign empty_res = res_q.empty;
	assign full_res  = res_q.full;

	// A result handed over by the core shows up in the output register
	a_handover: assert property (@(posedge clk) disable iff (!arst_n)
		core_valid && take |=> res_valid_q)
		else $error("result lost at handover");

endmodule

// ===== sv/blss_mem.sv =====
`timescale 1ns / 1ps
// Entry store: one write port and one read port, read data registered.
// No dependencies; instantiated by blss_core.
module blss_mem #(
	parameter int DEPTH     = 256,
	parameter int WORD_BITS = 32,
	parameter int AW        = 8
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rdata_q;

	// Write the entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read the entry, hold the data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/blss_core.sv =====
`timescale 1ns / 1ps
// Stack control: fill level, command sequencer and top-down search walk.
// Depends on blss_pkg and blss_mem.
module blss_core import blss_pkg::*; #(
	parameter int DEPTH     = 256,
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  logic [2:0]           cmd,
	input  logic [WORD_BITS-1:0] key,
	output logic                 cmd_stall,
	input  logic [8:0]           cap,
	output logic                 res_valid,
	input  logic                 res_take,
	output blss_res_t            res
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > 9) ? CW : 9;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SRCH = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]           state_q;
	logic [CW-1:0]        fill_q;
	logic [AW-1:0]        idx_q;
	logic [WORD_BITS-1:0] key_q;
	logic                 status_q;
	logic                 found_q;
	logic [AW-1:0]        pos_q;
	logic                 data_sel_q;

	logic                 accept;
	logic [CW-1:0]        fill_dec;
	logic [AW-1:0]        idx_dec;
	logic [CMPW-1:0]      cap_ext;
	logic [CMPW-1:0]      depth_ext;
	logic [CMPW-1:0]      eff_cap;
	logic                 is_full;
	logic                 is_empty;
	logic                 hit;
	logic                 mem_we;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;
	logic [WORD_BITS-1:0] rdata;
	logic signed [63:0]   rd_ext;

	// Effective capacity and flags
	assign cap_ext   = CMPW'(cap);
	assign depth_ext = CMPW'(DEPTH);
	assign eff_cap   = (cap_ext > depth_ext) ? depth_ext : cap_ext;
	assign is_full   = CMPW'(fill_q) >= eff_cap;
	assign is_empty  = (fill_q == '0);
	assign fill_dec  = fill_q - 1'b1;
	assign idx_dec   = idx_q - 1'b1;
	assign hit       = (rdata == key_q);

	assign accept    = cmd_valid && (state_q == ST_IDLE);
	assign cmd_stall = (state_q != ST_IDLE);

	// Drive the memory ports
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = fill_dec[AW-1:0];
		if (accept) begin
			case (cmd) inside
				CMD_PUSH:                        mem_we = !is_full;
				[CMD_POP:CMD_PEEK], CMD_SEARCH: mem_re = !is_empty;
				default:                         mem_re = 1'b0;
			endcase
		end else if (state_q == ST_SRCH) begin
			mem_re    = (idx_q != '0) && !hit;
			mem_raddr = idx_dec;
		end
	end

	blss_mem #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS),
		.AW        (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (fill_q[AW-1:0]),
		.wdata (key),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	// Sequence the commands and advance the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DONE;
						case (cmd)
							CMD_PUSH:   if (!is_full) fill_q <= fill_q + 1'b1;
							CMD_POP:    if (!is_empty) fill_q <= fill_dec;
							CMD_CLEAR:  fill_q <= '0;
							CMD_SEARCH: if (!is_empty) state_q <= ST_SRCH;
							default:    fill_q <= fill_q;
						endcase
					end
				end
				ST_SRCH: begin
					if (hit || idx_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Capture the per-item result fields and walk the search index
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q      <= key;
			idx_q      <= fill_dec[AW-1:0];
			status_q   <= 1'b0;
			found_q    <= 1'b0;
			pos_q      <= '0;
			data_sel_q <= 1'b0;
			case (cmd) inside
				CMD_PUSH: status_q <= is_full;
				[CMD_POP:CMD_PEEK]: begin
					status_q   <= is_empty;
					data_sel_q <= !is_empty;
				end
				default: status_q <= 1'b0;
			endcase
		end else if (state_q == ST_SRCH) begin
			if (hit) begin
				found_q <= 1'b1;
				pos_q   <= idx_q;
			end else if (idx_q != '0) begin
				idx_q <= idx_dec;
			end
		end
	end

	// Assemble the result item
	assign rd_ext    = 64'(signed'(rdata));
	assign res_valid = (state_q == ST_DONE);

	always_comb begin
		res          = '0;
		res.status   = status_q;
		res.data     = data_sel_q ? rd_ext[31:0] : 32'd0;
		res.found    = found_q;
		res.position = found_q ? 8'(pos_q) : 8'd0;
		res.count    = 9'(fill_q);
		res.empty    = is_empty;
		res.full     = is_full;
	end

	// A refused push leaves the fill level alone
	a_full_push_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == CMD_PUSH && is_full |=> fill_q == $past(fill_q))
		else $error("fill level moved on a refused push");

	// No write while the search walks the store
	a_no_write_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SRCH |-> !mem_we)
		else $error("memory written during search");

	// A finished result waits until it is taken
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && !res_take |=> state_q == ST_DONE)
		else $error("result dropped before it was taken");

	// The fill level never exceeds the store depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(fill_q) <= depth_ext)
		else $error("fill level beyond depth");

endmodule
